>>> rtl/position_frame_deframer_assert.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef POSITION_FRAME_DEFRAMER_ASSERT_SVH
`define POSITION_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define PFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("position_frame_deframer: same-cycle check failed");

// Next-cycle implication, also checked across reset.
`define PFD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("position_frame_deframer: next-cycle check failed");

`endif

>>> rtl/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

   localparam int PAYLOAD_WORDS_DEF = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_O  = 8'h4F;
   localparam logic [7:0] BYTE_K  = 8'h4B;

   typedef enum logic {
      KIND_WORD = 1'b0,
      KIND_ACK  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     bank;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pfd_if.sv
`default_nettype none

interface pfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  word_index;
   logic [31:0] word_value;
   logic        last;

   modport source (output valid, output kind, output word_index, output word_value,
                   output last, input ready);
   modport sink (input valid, input kind, input word_index, input word_value,
                 input last, output ready);
endinterface

`default_nettype wire

>>> rtl/pfd_queue.sv
`default_nettype none

module pfd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire pfd_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output pfd_pkg::cmd_type      head_cmd,
   output logic                  empty
);

   localparam int PW = pfd_pkg::idx_width(pfd_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(pfd_pkg::QUEUE_DEPTH + 1);

   pfd_pkg::cmd_type entry_ff [pfd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = (count_ff == CW'(pfd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(pfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(pfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pfd_front.sv
`default_nettype none

module pfd_front #(
   parameter int PAYLOAD_WORDS = pfd_pkg::PAYLOAD_WORDS_DEF,
   localparam int WIDX = pfd_pkg::idx_width(PAYLOAD_WORDS),
   localparam int AW = pfd_pkg::idx_width(2 * PAYLOAD_WORDS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   pfd_req_if.sink            req_ch,
   output logic               push_valid,
   output pfd_pkg::cmd_type   push_cmd,
   input  wire logic          queue_full,
   input  wire pfd_pkg::release_type rel,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [31:0]        wr_data
);

   localparam int CW = WIDX + 2;
   localparam logic [CW-1:0] LAST_BYTE = CW'(4 * PAYLOAD_WORDS - 1);

   typedef enum logic [4:0] {
      ST_HEADER  = 5'b00001,
      ST_SECOND  = 5'b00010,
      ST_PAYLOAD = 5'b00100,
      ST_FOOT_LF = 5'b01000,
      ST_FOOT_CR = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [23:0]   shift_ff, shift_in;
   logic          wr_bank_ff, wr_bank_in;
   logic [1:0]    busy_ff, busy_in;
   logic          blocked;
   logic          take;
   logic [7:0]    ch;
   logic [WIDX-1:0] word_sel;

   assign ch       = req_ch.rx_byte;
   assign word_sel = count_ff[CW-1:2];
   assign blocked  = (((state_ff == ST_SECOND) || (state_ff == ST_FOOT_CR)) && queue_full)
                     || ((state_ff == ST_PAYLOAD) && busy_ff[wr_bank_ff]);
   assign req_ch.ready = !blocked;
   assign take     = req_ch.valid && !blocked;

   assign wr_addr = wr_bank_ff ? (AW'(PAYLOAD_WORDS) + AW'(word_sel)) : AW'(word_sel);
   assign wr_data = {ch, shift_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      push_valid = 1'b0;
      push_cmd   = '{kind: pfd_pkg::KIND_WORD, bank: wr_bank_ff};
      wr_en      = 1'b0;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (take) begin
         unique case (state_ff)
            ST_HEADER: begin
               if ((ch == pfd_pkg::BYTE_CR) || (ch == pfd_pkg::BYTE_O)) begin
                  state_in = ST_SECOND;
               end
            end
            ST_SECOND: begin
               if (ch == pfd_pkg::BYTE_LF) begin
                  count_in = '0;
                  state_in = ST_PAYLOAD;
               end else if (ch == pfd_pkg::BYTE_K) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = pfd_pkg::KIND_ACK;
                  state_in      = ST_HEADER;
               end else if (ch != pfd_pkg::BYTE_CR) begin
                  state_in = ST_HEADER;
               end
            end
            ST_PAYLOAD: begin
               shift_in = {ch, shift_ff[23:8]};
               wr_en    = (count_ff[1:0] == 2'b11);
               if (count_ff == LAST_BYTE) begin
                  count_in = '0;
                  state_in = ST_FOOT_LF;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            ST_FOOT_LF: begin
               state_in = (ch == pfd_pkg::BYTE_LF) ? ST_FOOT_CR : ST_HEADER;
            end
            ST_FOOT_CR: begin
               if (ch == pfd_pkg::BYTE_CR) begin
                  push_valid          = 1'b1;
                  busy_in[wr_bank_ff] = 1'b1;
                  wr_bank_in          = !wr_bank_ff;
               end
               state_in = ST_HEADER;
            end
            default: begin
               state_in = ST_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HEADER;
         count_ff   <= '0;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

>>> rtl/pfd_back.sv
`default_nettype none

module pfd_back #(
   parameter int PAYLOAD_WORDS = pfd_pkg::PAYLOAD_WORDS_DEF,
   localparam int WIDX = pfd_pkg::idx_width(PAYLOAD_WORDS),
   localparam int AW = pfd_pkg::idx_width(2 * PAYLOAD_WORDS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pfd_pkg::cmd_type head_cmd,
   input  wire logic          queue_empty,
   output logic               pop,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   output pfd_pkg::release_type rel,
   pfd_rsp_if.source          rsp_ch
);

   logic [31:0] mem [2 * PAYLOAD_WORDS];
   logic [31:0] rdata_ff;

   logic             active_ff, active_in;
   pfd_pkg::cmd_type cmd_ff, cmd_in;
   logic [WIDX-1:0]  word_ff, word_in;

   logic       s1_valid_ff, s1_valid_in;
   pfd_pkg::kind_type s1_kind_ff;
   logic [2:0] s1_idx_ff;
   logic       s1_last_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   logic [2:0]  out_idx_ff;
   logic [31:0] out_value_ff;
   logic        out_last_ff;

   logic          s1_move;
   logic          issue;
   logic          issue_last;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign issue      = active_ff && (!s1_valid_ff || s1_move);
   assign issue_last = (cmd_ff.kind == pfd_pkg::KIND_ACK)
                       || (word_ff == WIDX'(PAYLOAD_WORDS - 1));
   assign rd_en      = issue && (cmd_ff.kind == pfd_pkg::KIND_WORD);
   assign rd_addr    = cmd_ff.bank ? (AW'(PAYLOAD_WORDS) + AW'(word_ff)) : AW'(word_ff);
   assign pop        = !active_ff && !queue_empty;
   assign rel.valid  = rd_en && issue_last;
   assign rel.bank   = cmd_ff.bank;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.kind       = out_kind_ff;
   assign rsp_ch.word_index = out_idx_ff;
   assign rsp_ch.word_value = out_value_ff;
   assign rsp_ch.last       = out_last_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      word_in   = word_ff;
      if (pop) begin
         active_in = 1'b1;
         cmd_in    = head_cmd;
         word_in   = '0;
      end else if (issue) begin
         if (issue_last) begin
            active_in = 1'b0;
         end else begin
            word_in = word_ff + 1'b1;
         end
      end
      s1_valid_in  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      word_ff <= word_in;
      if (issue) begin
         s1_kind_ff <= cmd_ff.kind;
         s1_idx_ff  <= 3'(word_ff);
         s1_last_ff <= issue_last;
      end
      if (s1_move) begin
         out_kind_ff  <= s1_kind_ff;
         out_idx_ff   <= s1_idx_ff;
         out_value_ff <= (s1_kind_ff == pfd_pkg::KIND_ACK) ? 32'd0 : rdata_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/position_frame_deframer.sv
// Channel   Dir   Transfer when          Payload
// req_ch    in    valid && ready         rx_byte[7:0]
// rsp_ch    out   valid && ready         kind, word_index[2:0], word_value[31:0], last
//
// One byte per cycle is taken while ready; the parser state is the only per-byte loop.
// A good footer yields PAYLOAD_WORDS results, one per cycle while rsp_ch is ready,
// from the payload RAM's single read port via a read stage and an output register.
// The payload RAM holds two frames; payload bytes stall while both are pending.
// A byte after a header start or at the closing footer stalls while the queue is full.
// Reset is synchronous and active high; the RAM needs no clearing pass.
`default_nettype none
`include "position_frame_deframer_assert.svh"

module position_frame_deframer #(
   parameter int PAYLOAD_WORDS = pfd_pkg::PAYLOAD_WORDS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pfd_req_if.sink   req_ch,
   pfd_rsp_if.source rsp_ch
);

   localparam int AW = pfd_pkg::idx_width(2 * PAYLOAD_WORDS);

   logic                 push_valid;
   pfd_pkg::cmd_type     push_cmd;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 pop;
   pfd_pkg::cmd_type     head_cmd;
   pfd_pkg::release_type rel;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [31:0]          wr_data;

   pfd_front #(
      .PAYLOAD_WORDS(PAYLOAD_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .rel        (rel),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   pfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .empty      (queue_empty)
   );

   pfd_back #(
      .PAYLOAD_WORDS(PAYLOAD_WORDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rel         (rel),
      .rsp_ch      (rsp_ch)
   );

   `PFD_ASSERT_IMP(a_ack_is_last, clock, reset, rsp_ch.valid && rsp_ch.kind, rsp_ch.last && (rsp_ch.word_value == 32'd0))
   `PFD_ASSERT_IMP(a_last_word_index, clock, reset, rsp_ch.valid && !rsp_ch.kind && rsp_ch.last, rsp_ch.word_index == 3'(PAYLOAD_WORDS - 1))
   `PFD_ASSERT_IMP(a_no_push_when_full, clock, reset, push_valid, !queue_full)
   `PFD_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_ch.valid && req_ch.ready)

endmodule

`default_nettype wire

>>> bench/position_frame_deframer_test.sv
`timescale 1ns / 1ps

module position_frame_deframer_test;

   localparam int PAYLOAD_WORDS = pfd_pkg::PAYLOAD_WORDS_DEF;
   localparam int PAYLOAD_BYTES = PAYLOAD_WORDS * 4;
   localparam int RANDOM_ITEMS = 480;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED_ROWS = 16;

   typedef enum logic [2:0] {
      PHASE_HEADER    = 3'd0,
      PHASE_HEADER_LF = 3'd1,
      PHASE_PAYLOAD   = 3'd2,
      PHASE_FOOTER_LF = 3'd3,
      PHASE_FOOTER_CR = 3'd4
   } parse_phase_type;

   typedef struct {
      pfd_pkg::kind_type kind;
      logic [2:0]        word_index;
      logic [31:0]       word_value;
      logic              last;
   } deframe_result_type;

   typedef struct {
      logic [7:0] rx_byte;
      int         copies;
      bit         ack_typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pfd_req_if req_bus ();
   pfd_rsp_if rsp_bus ();

   position_frame_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   deframe_result_type pending_results [$];
   parse_phase_type    model_phase = PHASE_HEADER;
   int                 model_count = 0;
   logic [7:0]         model_store [PAYLOAD_BYTES];

   int error_count = 0;
   int idle_cycles = 0;
   int rsp_stall_left = 0;
   bit rsp_burst = 1'b0;
   bit send_burst = 1'b0;

   logic [7:0] marker_bytes [6] = '{8'h00, 8'hFF, pfd_pkg::BYTE_CR, pfd_pkg::BYTE_LF,
                                    pfd_pkg::BYTE_O, pfd_pkg::BYTE_K};

   // Payload bytes of the directed frame form three all-ones words and three zero words.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{pfd_pkg::BYTE_K,  1,  1'b0},
      '{8'h00,            1,  1'b0},
      '{8'hFF,            1,  1'b0},
      '{pfd_pkg::BYTE_O,  1,  1'b0},
      '{pfd_pkg::BYTE_K,  1,  1'b1},
      '{pfd_pkg::BYTE_CR, 1,  1'b0},
      '{pfd_pkg::BYTE_CR, 1,  1'b0},
      '{pfd_pkg::BYTE_K,  1,  1'b1},
      '{pfd_pkg::BYTE_O,  1,  1'b0},
      '{8'h41,            1,  1'b0},
      '{pfd_pkg::BYTE_O,  1,  1'b0},
      '{pfd_pkg::BYTE_LF, 1,  1'b0},
      '{8'hFF,            12, 1'b0},
      '{8'h00,            12, 1'b0},
      '{pfd_pkg::BYTE_LF, 1,  1'b0},
      '{pfd_pkg::BYTE_CR, 1,  1'b0}
   };

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void parse_byte(input logic [7:0] rx, input bit record);
      deframe_result_type r;
      int w;
      case (model_phase)
         PHASE_HEADER: begin
            model_phase = (rx == pfd_pkg::BYTE_CR || rx == pfd_pkg::BYTE_O) ?
                          PHASE_HEADER_LF : PHASE_HEADER;
         end
         PHASE_HEADER_LF: begin
            if (rx == pfd_pkg::BYTE_LF) begin
               model_count = 0;
               model_phase = PHASE_PAYLOAD;
            end else if (rx == pfd_pkg::BYTE_K) begin
               r.kind = pfd_pkg::KIND_ACK;
               r.word_index = 3'd0;
               r.word_value = 32'd0;
               r.last = 1'b1;
               if (record) pending_results.push_back(r);
               model_phase = PHASE_HEADER;
            end else if (rx != pfd_pkg::BYTE_CR) begin
               model_phase = PHASE_HEADER;
            end
         end
         PHASE_PAYLOAD: begin
            model_store[model_count] = rx;
            model_count++;
            if (model_count == PAYLOAD_BYTES) begin
               model_count = 0;
               model_phase = PHASE_FOOTER_LF;
            end
         end
         PHASE_FOOTER_LF: begin
            model_phase = (rx == pfd_pkg::BYTE_LF) ? PHASE_FOOTER_CR : PHASE_HEADER;
         end
         PHASE_FOOTER_CR: begin
            if (rx == pfd_pkg::BYTE_CR && record) begin
               for (w = 0; w < PAYLOAD_WORDS; w++) begin
                  r.kind = pfd_pkg::KIND_WORD;
                  r.word_index = 3'(w);
                  r.word_value = {model_store[4 * w + 3], model_store[4 * w + 2],
                                  model_store[4 * w + 1], model_store[4 * w]};
                  r.last = (w == PAYLOAD_WORDS - 1);
                  pending_results.push_back(r);
               end
            end
            model_phase = PHASE_HEADER;
         end
         default: begin
            model_phase = PHASE_HEADER;
         end
      endcase
   endfunction

   // Returns in the time step of the transfer, with the byte still on the bus.
   task automatic feed_byte(input logic [7:0] rx, input bit record);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      parse_byte(rx, record);
   endtask

   always @(posedge clock) begin : rsp_pacing
      int n;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
         n = rsp_burst ? 0 : $urandom_range(0, 11);
         rsp_stall_left <= n;
         rsp_bus.ready <= (n == 0);
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_bus.ready <= (rsp_stall_left == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      deframe_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected, word_value", rsp_bus.word_value,
                            32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch("kind", 32'(rsp_bus.kind), 32'(want.kind));
            if (rsp_bus.word_index !== want.word_index)
               report_mismatch("word_index", 32'(rsp_bus.word_index), 32'(want.word_index));
            if (rsp_bus.word_value !== want.word_value)
               report_mismatch("word_value", rsp_bus.word_value, want.word_value);
            if (rsp_bus.last !== want.last)
               report_mismatch("last", 32'(rsp_bus.last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      deframe_result_type ack;
      logic [7:0] seq [$];
      int sent;
      int pick;
      int extra;
      int spot;
      int i;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      ack.kind = pfd_pkg::KIND_ACK;
      ack.word_index = 3'd0;
      ack.word_value = 32'd0;
      ack.last = 1'b1;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         repeat (directed_rows[i].copies) begin
            feed_byte(directed_rows[i].rx_byte, !directed_rows[i].ack_typed);
            if (directed_rows[i].ack_typed) pending_results.push_back(ack);
         end
      end

      // Mostly frames and acknowledges with random content; the rest is broken
      // frames and noise.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seq.delete();
         send_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            seq.push_back($urandom_range(0, 1) ? pfd_pkg::BYTE_CR : pfd_pkg::BYTE_O);
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
            repeat (extra) seq.push_back(pfd_pkg::BYTE_CR);
            seq.push_back(pfd_pkg::BYTE_LF);
            repeat (PAYLOAD_BYTES) begin
               if ($urandom_range(0, 7) == 0) seq.push_back(marker_bytes[$urandom_range(0, 5)]);
               else seq.push_back(8'($urandom_range(0, 255)));
            end
            seq.push_back(pfd_pkg::BYTE_LF);
            seq.push_back(pfd_pkg::BYTE_CR);
            if (pick >= 45) begin
               case ($urandom_range(0, 3))
                  0: spot = extra + 1;
                  1: spot = seq.size() - 2;
                  2: spot = seq.size() - 1;
                  default: spot = -1;
               endcase
               if (spot >= 0) begin
                  seq[spot] = $urandom_range(0, 1) ? marker_bytes[$urandom_range(0, 5)]
                                                   : 8'($urandom_range(0, 255));
               end else begin
                  spot = $urandom_range(1, seq.size() - 1);
                  while (seq.size() > spot) void'(seq.pop_back());
               end
            end
         end else if (pick < 80) begin
            seq.push_back($urandom_range(0, 1) ? pfd_pkg::BYTE_CR : pfd_pkg::BYTE_O);
            repeat ($urandom_range(0, 2)) seq.push_back(pfd_pkg::BYTE_CR);
            seq.push_back(pfd_pkg::BYTE_K);
         end else begin
            repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
         end
         foreach (seq[j]) feed_byte(seq[j], 1'b1);
         sent += seq.size();
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results left waiting", 32'd0, 32'(pending_results.size()));

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
